### sv/ata_seq_pkg.sv
// package for the ata pio sector sequencer
// types, codes and constants shared by every module; no dependencies
`default_nettype none

package ata_seq_pkg;

    localparam int unsigned CFG_W   = 23;
    localparam int unsigned CFG_IW  = 2;
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = 1;
    localparam int unsigned STEP_W  = 3;

    localparam logic [CFG_IW-1:0] REG_PORT_BASE    = 2'd0;
    localparam logic [CFG_IW-1:0] REG_POLL_LIMIT   = 2'd1;
    localparam logic [CFG_IW-1:0] REG_DRIVE_SELECT = 2'd2;

    localparam logic [15:0] PORT_BASE_RST  = 16'd496;
    localparam logic [22:0] POLL_LIMIT_RST = 23'h400000;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_STATUS = 2'd1;
    localparam logic [1:0] MODE_DATA   = 2'd2;

    localparam logic [2:0] ACT_READ_STATUS = 3'd0;
    localparam logic [2:0] ACT_WRITE_REG   = 3'd1;
    localparam logic [2:0] ACT_READ_DATA   = 3'd2;
    localparam logic [2:0] ACT_WRITE_DATA  = 3'd3;
    localparam logic [2:0] ACT_WANT_WORD   = 3'd4;
    localparam logic [2:0] ACT_DONE        = 3'd5;
    localparam logic [2:0] ACT_FAILED      = 3'd6;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NOT_READY  = 3'd1;
    localparam logic [2:0] ERR_BUSY_TO    = 3'd2;
    localparam logic [2:0] ERR_SEEK_TO    = 3'd3;
    localparam logic [2:0] ERR_DRIVE      = 3'd4;
    localparam logic [2:0] ERR_NO_DRQ     = 3'd5;

    localparam int unsigned ST_BSY  = 7;
    localparam int unsigned ST_DRDY = 6;
    localparam int unsigned ST_DSC  = 4;
    localparam int unsigned ST_DRQ  = 3;
    localparam int unsigned ST_ERR  = 0;

    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] SECTOR_COUNT_ONE = 8'h01;

    localparam logic [15:0] OFS_DATA    = 16'd0;
    localparam logic [15:0] OFS_COUNT   = 16'd2;
    localparam logic [15:0] OFS_LBA_LO  = 16'd3;
    localparam logic [15:0] OFS_LBA_MID = 16'd4;
    localparam logic [15:0] OFS_LBA_HI  = 16'd5;
    localparam logic [15:0] OFS_DEVICE  = 16'd6;
    localparam logic [15:0] OFS_STATUS  = 16'd7;

    localparam logic [22:0] POLL_MIN = 23'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic        direction;
        logic [27:0] lba;
        logic [7:0]  status_byte;
        logic [15:0] data_word;
    } request_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] port_address;
        logic [7:0]  reg_value;
        logic [15:0] word_out;
        logic        word_valid;
        logic [2:0]  error_code;
        logic        last;
    } result_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_DRDY,
        PH_BSY1,
        PH_DSC,
        PH_ERRCHK,
        PH_BSY2,
        PH_BSY3,
        PH_DRQ,
        PH_RDATA,
        PH_WDATA
    } phase_t;

    typedef enum logic [2:0] {
        JOB_STATUS,
        JOB_FAIL,
        JOB_TASKFILE,
        JOB_COMMAND,
        JOB_WANT,
        JOB_READ_START,
        JOB_READ_WORD,
        JOB_WRITE_WORD
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [2:0]  code;
        logic        is_write;
        logic        final_word;
        logic [27:0] lba;
        logic [15:0] word;
    } job_t;

endpackage

`default_nettype wire

### sv/ata_seq_front.sv
// front of the sequencer: takes request transfers, runs the protocol phases
// and turns each request into a job descriptor; uses ata_seq_pkg
`default_nettype none

module ata_seq_front
    import ata_seq_pkg::*;
#(
    parameter int unsigned SECTOR_WORDS = 256
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire request_t           request,
    input  wire logic [CFG_W-1:0]   poll_limit,
    output logic                    job_valid,
    output job_t                    job
);

    localparam int unsigned WI_W = $clog2(SECTOR_WORDS + 1);

    phase_t            phase_reg, phase_next;
    logic [CFG_W-1:0]  poll_count_reg, poll_count_next;
    logic [27:0]       sector_address_reg, sector_address_next;
    logic              is_write_reg, is_write_next;
    logic [WI_W-1:0]   word_index_reg, word_index_next;

    logic              status_wait;
    logic              ok;
    logic [2:0]        code;
    logic              poll_low;
    logic              st_err;
    logic [WI_W-1:0]   wi_inc;
    logic              wi_final;
    logic              data_wait;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            poll_count_reg     <= '0;
            sector_address_reg <= '0;
            is_write_reg       <= 1'b0;
            word_index_reg     <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            poll_count_reg     <= poll_count_next;
            sector_address_reg <= sector_address_next;
            is_write_reg       <= is_write_next;
            word_index_reg     <= word_index_next;
        end
    end

    // wait conditions per phase
    always_comb
    begin
        status_wait = 1'b1;
        ok          = 1'b0;
        code        = ERR_NONE;
        case (phase_reg)
            PH_DRDY:
            begin
                ok   = request.status_byte[ST_DRDY];
                code = ERR_NOT_READY;
            end
            PH_BSY1, PH_BSY2, PH_BSY3:
            begin
                ok   = !request.status_byte[ST_BSY];
                code = ERR_BUSY_TO;
            end
            PH_DSC:
            begin
                ok   = request.status_byte[ST_DSC];
                code = ERR_SEEK_TO;
            end
            PH_DRQ:
            begin
                ok   = request.status_byte[ST_DRQ];
                code = ERR_NO_DRQ;
            end
            PH_ERRCHK:
            begin
                ok = 1'b1;
            end
            default:
            begin
                status_wait = 1'b0;
            end
        endcase
    end

    assign poll_low  = poll_count_reg < POLL_MIN;
    assign st_err    = request.status_byte[ST_ERR];
    assign wi_inc    = word_index_reg + WI_W'(1);
    assign wi_final  = wi_inc >= WI_W'(SECTOR_WORDS);
    assign data_wait = (phase_reg == PH_RDATA) || (phase_reg == PH_WDATA);

    // next state
    always_comb
    begin
        phase_next          = phase_reg;
        poll_count_next     = poll_count_reg;
        sector_address_next = sector_address_reg;
        is_write_next       = is_write_reg;
        word_index_next     = word_index_reg;
        if (take)
        begin
            case (request.mode)
                MODE_START:
                begin
                    is_write_next       = request.direction;
                    sector_address_next = request.lba;
                    word_index_next     = '0;
                    poll_count_next     = poll_limit;
                    phase_next          = PH_DRDY;
                end
                MODE_STATUS:
                begin
                    if (status_wait)
                    begin
                        if (!ok)
                        begin
                            if (poll_low)
                                phase_next = PH_IDLE;
                            else
                                poll_count_next = poll_count_reg - CFG_W'(1);
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_DRDY:
                                begin
                                    phase_next      = PH_BSY1;
                                    poll_count_next = poll_limit;
                                end
                                PH_BSY1:
                                begin
                                    phase_next      = PH_DSC;
                                    poll_count_next = poll_limit;
                                end
                                PH_DSC:
                                begin
                                    phase_next = PH_ERRCHK;
                                end
                                PH_ERRCHK:
                                begin
                                    if (st_err)
                                        phase_next = PH_IDLE;
                                    else
                                    begin
                                        phase_next      = PH_BSY2;
                                        poll_count_next = poll_limit;
                                    end
                                end
                                PH_BSY2:
                                begin
                                    phase_next      = PH_BSY3;
                                    poll_count_next = poll_limit;
                                end
                                PH_BSY3:
                                begin
                                    phase_next      = PH_DRQ;
                                    poll_count_next = poll_limit;
                                end
                                default:
                                begin
                                    word_index_next = '0;
                                    phase_next = is_write_reg ? PH_WDATA : PH_RDATA;
                                end
                            endcase
                        end
                    end
                end
                MODE_DATA:
                begin
                    if (data_wait)
                    begin
                        word_index_next = wi_inc;
                        if (wi_final)
                            phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // job descriptor
    always_comb
    begin
        job_valid      = 1'b0;
        job.kind       = JOB_STATUS;
        job.code       = code;
        job.is_write   = is_write_reg;
        job.final_word = wi_final;
        job.lba        = sector_address_reg;
        job.word       = request.data_word;
        if (take)
        begin
            case (request.mode)
                MODE_START:
                begin
                    job_valid = 1'b1;
                end
                MODE_STATUS:
                begin
                    job_valid = status_wait;
                    if (!ok)
                    begin
                        if (poll_low)
                            job.kind = JOB_FAIL;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_ERRCHK:
                            begin
                                job.code = ERR_DRIVE;
                                job.kind = st_err ? JOB_FAIL : JOB_TASKFILE;
                            end
                            PH_BSY2:
                            begin
                                job.kind = JOB_COMMAND;
                            end
                            PH_DRQ:
                            begin
                                job.kind = is_write_reg ? JOB_WANT : JOB_READ_START;
                            end
                            default:
                            begin
                                job.kind = JOB_STATUS;
                            end
                        endcase
                    end
                end
                MODE_DATA:
                begin
                    job_valid = data_wait;
                    job.kind  = (phase_reg == PH_WDATA) ? JOB_WRITE_WORD : JOB_READ_WORD;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/ata_seq_queue.sv
// two-entry descriptor queue between front and back
// depends on ata_seq_pkg for job_t and the depth constants
`default_nettype none

module ata_seq_queue
    import ata_seq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr,
    input  wire job_t   wr_job,
    input  wire logic   rd,
    output logic        full,
    output logic        not_empty,
    output job_t        head
);

    localparam logic [Q_AW:0]   CNT_FULL = (Q_AW + 1)'(Q_DEPTH);
    localparam logic [Q_AW-1:0] PTR_LAST = Q_AW'(Q_DEPTH - 1);

    job_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;
    logic            do_wr;
    logic            do_rd;

    assign full      = count_reg == CNT_FULL;
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];
    assign do_wr     = wr && !full;
    assign do_rd     = rd && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + Q_AW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + Q_AW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + (Q_AW + 1)'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - (Q_AW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_job;
    end

endmodule

`default_nettype wire

### sv/ata_seq_back.sv
// back of the sequencer, depends on ata_seq_pkg: expands job descriptors
// into result transfers, one per cycle into an output register with room
`default_nettype none

module ata_seq_back
    import ata_seq_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire job_t          q_head,
    output logic               q_pop,
    input  wire logic [15:0]   port_base,
    input  wire logic          drive_select,
    input  wire logic          pop,
    output logic               empty,
    output result_t            result
);

    logic               busy_reg, busy_next;
    job_t               job_reg, job_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    job_t               cur;
    logic [STEP_W-1:0]  cur_step;
    logic               slot_free;
    logic               fire;
    logic               is_last;
    result_t            res;

    assign cur       = busy_reg ? job_reg : q_head;
    assign cur_step  = busy_reg ? step_reg : '0;
    assign slot_free = !out_valid_reg || pop;
    assign fire      = (busy_reg || q_valid) && slot_free;
    assign q_pop     = fire && !busy_reg;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    // result for the current step
    always_comb
    begin
        res.action       = ACT_READ_STATUS;
        res.port_address = port_base + OFS_STATUS;
        res.reg_value    = '0;
        res.word_out     = '0;
        res.word_valid   = 1'b0;
        res.error_code   = ERR_NONE;
        is_last          = 1'b1;
        case (cur.kind)
            JOB_FAIL:
            begin
                res.action       = ACT_FAILED;
                res.port_address = '0;
                res.error_code   = cur.code;
            end
            JOB_TASKFILE:
            begin
                is_last    = 1'b0;
                res.action = ACT_WRITE_REG;
                case (cur_step)
                    3'd0:
                    begin
                        res.port_address = port_base + OFS_COUNT;
                        res.reg_value    = SECTOR_COUNT_ONE;
                    end
                    3'd1:
                    begin
                        res.port_address = port_base + OFS_LBA_LO;
                        res.reg_value    = cur.lba[7:0];
                    end
                    3'd2:
                    begin
                        res.port_address = port_base + OFS_LBA_MID;
                        res.reg_value    = cur.lba[15:8];
                    end
                    3'd3:
                    begin
                        res.port_address = port_base + OFS_LBA_HI;
                        res.reg_value    = cur.lba[23:16];
                    end
                    3'd4:
                    begin
                        res.port_address = port_base + OFS_DEVICE;
                        res.reg_value    = {2'b01, 1'b0, drive_select, cur.lba[27:24]};
                    end
                    default:
                    begin
                        res.action = ACT_READ_STATUS;
                        is_last    = 1'b1;
                    end
                endcase
            end
            JOB_COMMAND:
            begin
                if (cur_step == '0)
                begin
                    is_last       = 1'b0;
                    res.action    = ACT_WRITE_REG;
                    res.reg_value = cur.is_write ? CMD_WRITE : CMD_READ;
                end
            end
            JOB_WANT:
            begin
                res.action       = ACT_WANT_WORD;
                res.port_address = '0;
            end
            JOB_READ_START:
            begin
                res.action       = ACT_READ_DATA;
                res.port_address = port_base + OFS_DATA;
            end
            JOB_READ_WORD:
            begin
                res.word_out   = cur.word;
                res.word_valid = 1'b1;
                if (cur.final_word)
                begin
                    res.action       = ACT_DONE;
                    res.port_address = '0;
                end
                else
                begin
                    res.action       = ACT_READ_DATA;
                    res.port_address = port_base + OFS_DATA;
                end
            end
            JOB_WRITE_WORD:
            begin
                if (cur_step == '0)
                begin
                    is_last          = 1'b0;
                    res.action       = ACT_WRITE_DATA;
                    res.port_address = port_base + OFS_DATA;
                    res.word_out     = cur.word;
                end
                else
                begin
                    res.action       = cur.final_word ? ACT_DONE : ACT_WANT_WORD;
                    res.port_address = '0;
                end
            end
            default:
            begin
            end
        endcase
        res.last = is_last;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        job_next       = job_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
            busy_next      = !is_last;
            job_next       = cur;
            step_next      = cur_step + STEP_W'(1);
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

### sv/ata_pio_sector_sequencer.sv
// top level of the ata pio lba28 single-sector sequencer: configuration
// registers, front, descriptor queue and back; depends on ata_seq_pkg and
// ata_seq_front, ata_seq_queue, ata_seq_back
//
//   channel   signals                        transfer when
//   request   push, full, request            push && !full
//   result    empty, pop, result             pop && !empty
//   config    cfg_we, cfg_index, cfg_data    cfg_we
//
// the front takes one request per cycle while the queue has room; each request
// that is not ignored becomes one descriptor. the back emits one result per cycle
// while its output register is free or popped; a request with k results holds
// the back for all k of them (1 to 6, the task file write is the longest). a
// two-entry queue and the output register let either side stall.
// reset clears all phases, the queue and the output register, and loads the
// configuration defaults.
`default_nettype none

module ata_pio_sector_sequencer
    import ata_seq_pkg::*;
#(
    parameter int unsigned SECTOR_WORDS = 256
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire request_t          request,
    output logic                   empty,
    input  wire logic              pop,
    output result_t                result,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    logic [15:0]      port_base_reg;
    logic [CFG_W-1:0] poll_limit_reg;
    logic             drive_select_reg;

    logic   take;
    logic   job_valid;
    job_t   job;
    logic   q_valid;
    job_t   q_head;
    logic   q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_base_reg    <= PORT_BASE_RST;
            poll_limit_reg   <= POLL_LIMIT_RST;
            drive_select_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PORT_BASE:    port_base_reg    <= cfg_data[15:0];
                REG_POLL_LIMIT:   poll_limit_reg   <= cfg_data;
                REG_DRIVE_SELECT: drive_select_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign take = push && !full;

    ata_seq_front #(
        .SECTOR_WORDS (SECTOR_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .request    (request),
        .poll_limit (poll_limit_reg),
        .job_valid  (job_valid),
        .job        (job)
    );

    ata_seq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (job_valid),
        .wr_job    (job),
        .rd        (q_pop),
        .full      (full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    ata_seq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .port_base    (port_base_reg),
        .drive_select (drive_select_reg),
        .pop          (pop),
        .empty        (empty),
        .result       (result)
    );

endmodule

`default_nettype wire
